/* design/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// Holds the transaction structs, request and status codes and the
// controller-to-datapath command struct. No dependencies.
package spq_pkg;

  // Default number of cells and the capacity value after reset.
  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned CAP_W         = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request codes.
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // One request transaction.
  typedef struct packed {
    logic        req_type;
    logic [9:0]  entry_id;
    logic [7:0]  remaining_count;
    logic [15:0] arrival_stamp;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic [9:0]  head_id;
    logic [7:0]  head_count;
    logic [15:0] head_stamp;
    logic [4:0]  occupancy;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;   // capture the accepted request
    logic latch_cmp;  // register per-cell compare results and refusal
    logic do_update;  // shift cells, update fill and load the result
  } spq_cmd_t;

endpackage

/* design/spq_datapath.sv */
// Datapath of the sorted priority queue: the row of sorted cells, the fill
// counter, the capacity register and the result register.
// Depends on spq_pkg; driven by commands from spq_ctrl.
module spq_datapath
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  spq_cmd_t         cmd_i,
  input  in_item_t         in_item,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  output out_item_t        out_item
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // true when a held entry is served after the new one
  function automatic logic ranks_below(input logic [7:0]  cell_cnt,
                                       input logic [15:0] cell_stamp,
                                       input logic [7:0]  new_cnt,
                                       input logic [15:0] new_stamp);
    if (cell_cnt != new_cnt) begin
      return cell_cnt < new_cnt;
    end
    return cell_stamp > new_stamp;
  endfunction

  logic [CAP_W-1:0] cap_r;
  in_item_t         req_r;
  logic [9:0]       id_r    [DEPTH];
  logic [7:0]       cnt_r   [DEPTH];
  logic [15:0]      stamp_r [DEPTH];
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic [DEPTH-1:0] below_r;
  logic [DEPTH-1:0] below_nxt;
  logic             refuse_r;
  logic             refuse_nxt;
  out_item_t        out_r;
  out_item_t        out_nxt;

  logic [CMP_W-1:0] limit;
  logic             full;
  logic [DEPTH-1:0] shift_in;
  logic [DEPTH-1:0] ins_here;
  logic [IDX_W-1:0] ins_idx;

  // Hold the capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // Capture the accepted request
  always_ff @(posedge clk) begin
    if (cmd_i.load_req) begin
      req_r <= in_item;
    end
  end

  // Limit in force is the smaller of capacity and the cell count
  always_comb begin
    limit = (CMP_W'(cap_r) < CMP_W'(DEPTH)) ? CMP_W'(cap_r) : CMP_W'(DEPTH);
    full  = CMP_W'(fill_r) >= limit;
  end

  // Compare the new entry against every occupied cell at once
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      below_nxt[i] = (CNT_W'(i) < fill_r) &&
                     ranks_below(cnt_r[i], stamp_r[i],
                                 req_r.remaining_count, req_r.arrival_stamp);
    end
    if (req_r.req_type == REQ_DEQ) begin
      refuse_nxt = (fill_r == '0);
    end else begin
      refuse_nxt = full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.latch_cmp) begin
      below_r  <= below_nxt;
      refuse_r <= refuse_nxt;
    end
  end

  // Decode where each cell takes its next value from on an enqueue
  always_comb begin
    ins_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      shift_in[i] = (i > 0) ? below_r[(i > 0) ? i - 1 : 0] : 1'b0;
      ins_here[i] = !shift_in[i] && (below_r[i] || (CNT_W'(i) == fill_r));
      if (ins_here[i]) begin
        ins_idx = ins_idx | IDX_W'(i);
      end
    end
  end

  // Next fill level and result
  always_comb begin
    fill_nxt = fill_r;
    out_nxt  = '0;
    if (req_r.req_type == REQ_DEQ) begin
      if (refuse_r) begin
        out_nxt.status = STAT_EMPTY;
      end else begin
        fill_nxt           = fill_r - 1'b1;
        out_nxt.status     = STAT_OK;
        out_nxt.head_id    = id_r[0];
        out_nxt.head_count = cnt_r[0];
        out_nxt.head_stamp = stamp_r[0];
      end
    end else begin
      if (refuse_r) begin
        out_nxt.status = STAT_FULL;
      end else begin
        fill_nxt       = fill_r + 1'b1;
        out_nxt.status = STAT_OK;
        out_nxt.slot   = 4'(ins_idx);
      end
    end
    out_nxt.occupancy = 5'(fill_nxt);
  end

  // Advance the fill counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd_i.do_update) begin
      fill_r <= fill_nxt;
    end
  end

  // Shift the cells: toward the tail behind an insert, toward the head on a dequeue
  always_ff @(posedge clk) begin
    if (cmd_i.do_update && !refuse_r) begin
      if (req_r.req_type == REQ_DEQ) begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          id_r[i]    <= id_r[i+1];
          cnt_r[i]   <= cnt_r[i+1];
          stamp_r[i] <= stamp_r[i+1];
        end
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (shift_in[i]) begin
            id_r[i]    <= id_r[(i > 0) ? i - 1 : 0];
            cnt_r[i]   <= cnt_r[(i > 0) ? i - 1 : 0];
            stamp_r[i] <= stamp_r[(i > 0) ? i - 1 : 0];
          end else if (ins_here[i]) begin
            id_r[i]    <= req_r.entry_id;
            cnt_r[i]   <= req_r.remaining_count;
            stamp_r[i] <= req_r.arrival_stamp;
          end
        end
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd_i.do_update) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

`ifndef SYNTHESIS
  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill level exceeds cell count");

  a_fill_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_i.do_update |=> $stable(fill_r))
    else $error("fill level changed outside an update");
`endif

endmodule

/* design/spq_ctrl.sv */
// Controller of the sorted priority queue: sequences accept, compare and
// update, and owns the input stall and the result valid flag.
// Depends on spq_pkg; drives spq_datapath through spq_cmd_t.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output spq_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   out_busy;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;

  // Sequence one transaction through compare and update
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (!out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Issue datapath commands
  always_comb begin
    cmd_o.load_req  = accept;
    cmd_o.latch_cmp = (state_r == ST_CMP);
    cmd_o.do_update = (state_r == ST_UPD) && !out_busy;
  end

  // Set valid on a new result, drop it once the result is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_o.do_update) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_CMP)
    else $error("accepted transaction did not enter compare");

  a_cmp_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |=> state_r == ST_UPD)
    else $error("compare not followed by update");

  a_update_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.do_update |=> out_valid_r && state_r == ST_IDLE)
    else $error("update did not present a result");
`endif

endmodule

/* design/sorted_priority_queue.sv */
// Sorted priority queue: a row of DEPTH cells kept in priority order, with
// an insert/remove sequencer. Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// Each request transaction passes through accept, a compare step in which
// every occupied cell is compared with the new entry in parallel, and an
// update step in which the cells shift and the result register is loaded.
// The next request is taken the cycle after the update, while the previous
// result may still wait in the output register; the update waits as long
// as an earlier result has not been taken. A larger remaining_count is
// served first, and on equal counts the smaller arrival_stamp; equal
// entries leave in arrival order. The capacity register (reset 16) caps
// the fill level at the smaller of capacity and DEPTH. The user must write
// it only while no transaction is in flight; the block does not enforce it.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_o     (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

endmodule
